### rtl/clrb_pkg.sv
`default_nettype none
package clrb_pkg;

  // ring size default
  localparam int unsigned RING_DEPTH_DEF = 128;

  // op codes
  localparam logic [2:0] OP_RX          = 3'd0;
  localparam logic [2:0] OP_READ        = 3'd1;
  localparam logic [2:0] OP_TX          = 3'd2;
  localparam logic [2:0] OP_SUM_RESTART = 3'd3;
  localparam logic [2:0] OP_SUM_STOP    = 3'd4;

  // characters
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;
  localparam logic [7:0] CHAR_DOT = 8'h2E;

  // banner mode that appends a dot
  localparam logic [1:0] BANNER_DOT = 2'd1;

  // config port
  localparam int unsigned ADDR_W = 3;
  localparam logic        REG_BANNER = 1'b0;  // register index, paddr[2]

  typedef struct packed {
    logic load;    // latch input beat
    logic exec;    // perform the op, load result register
    logic rd_cap;  // capture ring read data into result
    logic dot;     // turn result into the trailing dot
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_read;  // read op on a non-empty ring
    logic res_last;   // current result is the item's final one
  } dp_status_t;

endpackage
`default_nettype wire

### rtl/clrb_ctrl.sv
`default_nettype none
module clrb_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire clrb_pkg::dp_status_t status_i,
  output clrb_pkg::ctrl_cmd_t   cmd_o
);
  import clrb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXEC   = 4'b0010,
    ST_RDWAIT = 4'b0100,
    ST_OUT    = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = status_i.need_read ? ST_RDWAIT : ST_OUT;
      end
      ST_RDWAIT: begin
        cmd_o.rd_cap = 1'b1;
        state_d      = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          if (status_i.res_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.dot = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### rtl/clrb_dp.sv
`default_nettype none
module clrb_dp #(
  parameter int unsigned RING_DEPTH = clrb_pkg::RING_DEPTH_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire clrb_pkg::ctrl_cmd_t cmd_i,
  output clrb_pkg::dp_status_t     status_o,
  input  wire logic [1:0]          banner_i,
  input  wire logic [2:0]          op_i,
  input  wire logic [7:0]          data_byte_i,
  output logic                     tx_valid_o,
  output logic [7:0]               tx_byte_o,
  output logic                     rd_valid_o,
  output logic [7:0]               rd_byte_o,
  output logic                     rd_line_end_o,
  output logic [31:0]              drop_count_o,
  output logic [63:0]              sum_value_o
);
  import clrb_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);

  logic [2:0]    op_q;
  logic [7:0]    byte_q;
  logic [AW-1:0] head_addr_q, head_addr_d, tail_addr_q, tail_addr_d;
  logic          head_wrap_q, head_wrap_d, tail_wrap_q, tail_wrap_d;
  logic [31:0]   drops_q, drops_d;
  logic [63:0]   sum_q, sum_d;
  logic          sum_on_q, sum_on_d;

  logic [7:0]    mem_q [RING_DEPTH];
  logic [7:0]    mem_rdata_q;

  logic          txv_q, rdv_q, le_q, last_q;
  logic [7:0]    txb_q, rdb_q;

  logic          empty, full, emits, mem_we;
  logic [7:0]    b_conv;
  logic [AW-1:0] mem_waddr, head_prev;

  assign empty = (head_addr_q == tail_addr_q) && (head_wrap_q == tail_wrap_q);
  assign full  = (head_addr_q == tail_addr_q) && (head_wrap_q != tail_wrap_q);
  assign emits = (op_q == OP_RX) || (op_q == OP_TX);
  assign b_conv = ((op_q == OP_RX) && (byte_q == CHAR_CR)) ? CHAR_LF : byte_q;
  assign head_prev = (head_addr_q == '0) ? LAST_ADDR : head_addr_q - 1'b1;

  assign status_o.need_read = (op_q == OP_READ) && !empty;
  assign status_o.res_last  = last_q;

  // state update for the latched op
  always_comb begin
    head_addr_d = head_addr_q;
    head_wrap_d = head_wrap_q;
    tail_addr_d = tail_addr_q;
    tail_wrap_d = tail_wrap_q;
    drops_d     = drops_q;
    sum_d       = sum_q;
    sum_on_d    = sum_on_q;
    mem_we      = 1'b0;
    mem_waddr   = head_addr_q;
    if (cmd_i.exec) begin
      case (op_q)
        OP_RX: begin
          if (!full) begin
            mem_we = 1'b1;
            if (head_addr_q == LAST_ADDR) begin
              head_addr_d = '0;
              head_wrap_d = ~head_wrap_q;
            end else begin
              head_addr_d = head_addr_q + 1'b1;
            end
          end else begin
            if (drops_q != '1) drops_d = drops_q + 32'd1;
            // keep the line boundary: newline replaces the newest entry
            if (b_conv == CHAR_LF) begin
              mem_we    = 1'b1;
              mem_waddr = head_prev;
            end
          end
          if (sum_on_q) sum_d = sum_q + {56'd0, b_conv};
        end
        OP_READ: begin
          if (!empty) begin
            if (tail_addr_q == LAST_ADDR) begin
              tail_addr_d = '0;
              tail_wrap_d = ~tail_wrap_q;
            end else begin
              tail_addr_d = tail_addr_q + 1'b1;
            end
          end
        end
        OP_TX: begin
          if (sum_on_q) sum_d = sum_q + {56'd0, b_conv};
        end
        OP_SUM_RESTART: begin
          sum_d    = '0;
          sum_on_d = 1'b1;
        end
        OP_SUM_STOP: sum_on_d = 1'b0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_addr_q <= '0;
      head_wrap_q <= 1'b0;
      tail_addr_q <= '0;
      tail_wrap_q <= 1'b0;
      drops_q     <= '0;
      sum_q       <= '0;
      sum_on_q    <= 1'b0;
    end else begin
      head_addr_q <= head_addr_d;
      head_wrap_q <= head_wrap_d;
      tail_addr_q <= tail_addr_d;
      tail_wrap_q <= tail_wrap_d;
      drops_q     <= drops_d;
      sum_q       <= sum_d;
      sum_on_q    <= sum_on_d;
    end
  end

  // ring storage, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= b_conv;
    mem_rdata_q <= mem_q[tail_addr_q];
  end

  // input latch and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_i;
      byte_q <= data_byte_i;
    end
    if (cmd_i.exec) begin
      txv_q  <= emits;
      txb_q  <= emits ? b_conv : 8'd0;
      rdv_q  <= status_o.need_read;
      rdb_q  <= 8'd0;
      le_q   <= 1'b0;
      last_q <= !(emits && (banner_i == BANNER_DOT));
    end
    if (cmd_i.rd_cap) begin
      rdb_q <= mem_rdata_q;
      le_q  <= (mem_rdata_q == CHAR_LF) || (mem_rdata_q == CHAR_CR);
    end
    if (cmd_i.dot) begin
      txb_q  <= CHAR_DOT;
      last_q <= 1'b1;
    end
  end

  assign tx_valid_o    = txv_q;
  assign tx_byte_o     = txb_q;
  assign rd_valid_o    = rdv_q;
  assign rd_byte_o     = rdb_q;
  assign rd_line_end_o = le_q;
  assign drop_count_o  = drops_q;
  assign sum_value_o   = sum_q;

endmodule
`default_nettype wire

### rtl/console_line_ring_buffer_core.sv
`default_nettype none
// Console receive queue with echo and a 64-bit checksum summing received and transmitted
// bytes. One input beat is taken at a time: it is latched, executed against the ring
// and counters, and its result beat is then held until taken. A read of a non-empty
// ring passes through an extra wait state for the ring memory's registered read port.
// In banner mode 1 a received or transmitted byte gets one more result beat, the dot.
// The ring store needs no clearing pass after reset; its entries are only read once
// written. Register 0 (byte address 0, bits 1:0) is banner_mode and may only be
// written while no item is in flight.
module console_line_ring_buffer_core #(
  parameter int unsigned RING_DEPTH = clrb_pkg::RING_DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // input beats
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [2:0]                  op_i,
  input  wire logic [7:0]                  data_byte_i,
  // result beats
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             tx_valid_o,
  output logic [7:0]                       tx_byte_o,
  output logic                             rd_valid_o,
  output logic [7:0]                       rd_byte_o,
  output logic                             rd_line_end_o,
  output logic [31:0]                      drop_count_o,
  output logic [63:0]                      sum_value_o,
  output logic                             last_o,
  // APB config
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [clrb_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import clrb_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic [1:0] banner_q;

  // APB: zero wait states; register index is paddr[2]
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BANNER) ? {30'd0, banner_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      banner_q <= 2'd0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_BANNER)) begin
      banner_q <= pwdata[1:0];
    end
  end

  clrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  clrb_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .banner_i      (banner_q),
    .op_i          (op_i),
    .data_byte_i   (data_byte_i),
    .tx_valid_o    (tx_valid_o),
    .tx_byte_o     (tx_byte_o),
    .rd_valid_o    (rd_valid_o),
    .rd_byte_o     (rd_byte_o),
    .rd_line_end_o (rd_line_end_o),
    .drop_count_o  (drop_count_o),
    .sum_value_o   (sum_value_o)
  );

  // final-beat flag lives in the datapath's result register
  assign last_o = status.res_last;

endmodule
`default_nettype wire

### rtl/clrb_checker.sv
`default_nettype none
module clrb_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic                        tx_valid_o,
  input wire logic [7:0]                  tx_byte_o,
  input wire logic                        rd_valid_o,
  input wire logic [7:0]                  rd_byte_o,
  input wire logic                        rd_line_end_o,
  input wire logic                        last_o
);
  import clrb_pkg::*;

  // one item in flight: no new beat while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input accepted while result pending");

  // a non-final beat is always followed by the dot beat
  a_dot_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=>
      (out_valid_o && tx_valid_o && (tx_byte_o == CHAR_DOT) && last_o))
    else $error("missing dot beat");

  // fields of an absent byte read as zero
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((tx_valid_o || (tx_byte_o == 8'd0)) &&
                     (rd_valid_o || ((rd_byte_o == 8'd0) && !rd_line_end_o))))
    else $error("invalid field not zero");

  // an accepted input beat is executed before any result beat shows
  a_exec_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_o)
    else $error("result shown without execute cycle");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(tx_byte_o) && $stable(rd_byte_o) && $stable(last_o)))
    else $error("stalled result changed");

endmodule

bind console_line_ring_buffer_core clrb_checker u_clrb_checker (.*);
`default_nettype wire
